### rtl/sbx_pkg.sv
`timescale 1ns / 1ps

package sbx_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'h73;
    localparam logic [7:0] ACK_BYTE   = 8'h61;

    // configuration port
    localparam int unsigned ADDR_W         = 3;
    localparam logic [4:0]  DATA_LEN_RESET = 5'd4;
    localparam logic        REG_DATA_LEN   = 1'b0;

    // source of a result value
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_ACK  = 2'd1,
        SRC_SUM  = 2'd2
    } t_src;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic wr;
        logic rd;
        logic acc;
        logic drop;
        logic clear;
        logic sum_clr;
        logic out_ld;
        t_src out_src;
        logic out_kind;
        logic out_last;
    } t_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic is_start;
        logic match;
        logic out_free;
    } t_stat;

endpackage

### rtl/sbx_ctrl.sv
`timescale 1ns / 1ps

module sbx_ctrl #(
    parameter int unsigned MAX_DATA = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [4:0]                            i_data_len,
    input  logic                                  i_cfg_wr,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [$clog2(MAX_DATA + 3)-1:0]       i_fill,
    input  sbx_pkg::t_stat                        i_stat,
    output sbx_pkg::t_cmd                         o_cmd,
    output logic [$clog2(MAX_DATA + 3)-1:0]       o_rd_off,
    output logic [3:0]                            o_out_index
);

    localparam int unsigned DEPTH = MAX_DATA + 2;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned LW    = (CW > 5) ? CW : 5;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SEEK_RD  = 9'b000000010,
        S_SEEK_CHK = 9'b000000100,
        S_SUM      = 9'b000001000,
        S_SUM_END  = 9'b000010000,
        S_EMIT_RD  = 9'b000100000,
        S_EMIT_LD  = 9'b001000000,
        S_ACK_A    = 9'b010000000,
        S_ACK_S    = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] w_dl_ext;
    logic [CW-1:0] w_dlen;
    logic [CW-1:0] w_frame;
    logic [CW-1:0] w_idx;
    logic [CW+3:0] w_idx_ext;

    // active data length, clamped to 1..MAX_DATA
    assign w_dl_ext = LW'(i_data_len);
    always_comb begin
        if (w_dl_ext == '0) begin
            w_dlen = CW'(1);
        end else if (w_dl_ext > LW'(MAX_DATA)) begin
            w_dlen = CW'(MAX_DATA);
        end else begin
            w_dlen = w_dl_ext[CW-1:0];
        end
    end
    assign w_frame = w_dlen + CW'(2);

    // payload index, taken modulo 16
    assign w_idx       = r_cnt - CW'(1);
    assign w_idx_ext   = {4'b0000, w_idx};
    assign o_out_index = w_idx_ext[3:0];

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_rd_off = '0;
        o_cmd.out_src = sbx_pkg::SRC_DATA;
        o_cmd.clear   = i_cfg_wr;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_SEEK_RD;
                end
            end
            S_SEEK_RD: begin
                if (i_fill == '0) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_SEEK_CHK;
                end
            end
            S_SEEK_CHK: begin
                if (!i_stat.is_start) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_SEEK_RD;
                end else if (i_fill < w_frame) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sum_clr = 1'b1;
                    n_cnt         = CW'(1);
                    n_state       = S_SUM;
                end
            end
            S_SUM: begin
                // one read per cycle, data bytes then the checksum byte
                o_cmd.rd  = 1'b1;
                o_cmd.acc = (r_cnt <= w_dlen);
                o_rd_off  = r_cnt;
                if (r_cnt == w_dlen + CW'(1)) begin
                    n_state = S_SUM_END;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_SUM_END: begin
                if (i_stat.match) begin
                    n_cnt   = CW'(1);
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_SEEK_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                o_rd_off = r_cnt;
                n_state  = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (r_cnt == w_dlen) begin
                        n_state = S_ACK_A;
                    end else begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_ACK_A: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_src  = sbx_pkg::SRC_ACK;
                    o_cmd.out_kind = 1'b1;
                    n_state        = S_ACK_S;
                end
            end
            S_ACK_S: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_src  = sbx_pkg::SRC_SUM;
                    o_cmd.out_kind = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/sbx_dpath.sv
`timescale 1ns / 1ps

module sbx_dpath #(
    parameter int unsigned MAX_DATA = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sbx_pkg::t_cmd                         i_cmd,
    input  logic [7:0]                            i_rx_byte,
    input  logic [$clog2(MAX_DATA + 3)-1:0]       i_rd_off,
    input  logic [3:0]                            i_out_index,
    input  logic                                  i_stall,
    output logic [$clog2(MAX_DATA + 3)-1:0]       o_fill,
    output sbx_pkg::t_stat                        o_stat,
    output logic                                  o_valid,
    output logic                                  o_kind,
    output logic [7:0]                            o_value,
    output logic [3:0]                            o_index,
    output logic                                  o_last
);

    localparam int unsigned DEPTH = MAX_DATA + 2;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_rd_acc;
    logic [7:0]    r_sum;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_fill;
    logic          r_out_vld;
    logic          r_kind;
    logic [7:0]    r_value;
    logic [3:0]    r_index;
    logic          r_last;
    logic [AW-1:0] w_wr_slot;
    logic [AW-1:0] w_rd_slot;
    logic [AW-1:0] w_next_head;
    logic          w_out_free;
    logic [7:0]    w_out_val;

    // window offset to store slot, wraps once at most
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [CW:0] pos;
        pos = {1'b0, off} + (CW + 1)'(head);
        if (pos >= (CW + 1)'(DEPTH)) begin
            pos = pos - (CW + 1)'(DEPTH);
        end
        return pos[AW-1:0];
    endfunction

    assign w_wr_slot   = f_slot(r_head, r_fill);
    assign w_rd_slot   = f_slot(r_head, i_rd_off);
    assign w_next_head = f_slot(r_head, CW'(1));

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[w_wr_slot] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_rd_slot];
        end
    end

    // window head and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.wr) begin
            r_fill <= r_fill + CW'(1);
        end else if (i_cmd.drop && (r_fill != '0)) begin
            r_head <= w_next_head;
            r_fill <= r_fill - CW'(1);
        end
    end

    // checksum accumulator, one read behind the address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_acc <= 1'b0;
        end else begin
            r_rd_acc <= i_cmd.rd && i_cmd.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (r_rd_acc) begin
            r_sum <= r_sum ^ r_rdata;
        end
    end

    // result value select
    always_comb begin
        case (i_cmd.out_src)
            sbx_pkg::SRC_DATA: w_out_val = r_rdata;
            sbx_pkg::SRC_ACK:  w_out_val = sbx_pkg::ACK_BYTE;
            sbx_pkg::SRC_SUM:  w_out_val = r_sum;
            default:           w_out_val = r_rdata;
        endcase
    end

    // output register
    assign w_out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_kind  <= i_cmd.out_kind;
            r_value <= w_out_val;
            r_index <= i_cmd.out_kind ? 4'd0 : i_out_index;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_stat.is_start = (r_rdata == sbx_pkg::START_BYTE);
    assign o_stat.match    = (r_rdata == r_sum);
    assign o_stat.out_free = w_out_free;
    assign o_fill          = r_fill;
    assign o_valid         = r_out_vld;
    assign o_kind          = r_kind;
    assign o_value         = r_value;
    assign o_index         = r_index;
    assign o_last          = r_last;

endmodule

### rtl/start_byte_xor_frame_receiver.sv
`timescale 1ns / 1ps

// Start-byte framed receiver with XOR checksum.
// Input channel: one received byte per beat on i_rx_byte, i_valid / o_stall.
// Output channel: result beats on o_kind, o_value, o_index, o_last with
// o_valid / i_stall. A good frame yields data_len payload beats (kind 0,
// index 0..), then two acknowledge beats ('a', then the checksum, o_last).
// Config: APB-style port, data_len at address 0; a write empties the window.
// Sequence: a byte is stored, then the head of the window is checked and
// dropped, one byte at a time, while hunting for the start byte. A full
// window gets a checksum pass over the store read port, then each payload
// beat is read and loaded in turn, then the two acknowledge beats follow.
// All reads go through the single store read port; o_stall is high from
// the cycle after a byte beat until done.
// Reset empties the window and sets data_len to 4.
// While i_stall holds a result, the sequencer waits; the output register
// lets the next byte be taken while the last result still waits.
module start_byte_xor_frame_receiver #(
    parameter int unsigned MAX_DATA = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [7:0]                    o_value,
    output logic [3:0]                    o_index,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbx_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned DEPTH = MAX_DATA + 2;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [4:0]     r_data_len;
    logic           w_cfg_wr;
    logic           w_in_acc;
    logic [CW-1:0]  w_fill;
    logic [CW-1:0]  w_rd_off;
    logic [3:0]     w_out_index;
    sbx_pkg::t_cmd  w_cmd;
    sbx_pkg::t_stat w_stat;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == sbx_pkg::REG_DATA_LEN);
    assign prdata   = (paddr[2] == sbx_pkg::REG_DATA_LEN) ? {27'd0, r_data_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len <= sbx_pkg::DATA_LEN_RESET;
        end else if (w_cfg_wr) begin
            r_data_len <= pwdata[4:0];
        end
    end

    assign w_in_acc = i_valid && !o_stall;

    sbx_ctrl #(
        .MAX_DATA (MAX_DATA)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_len  (r_data_len),
        .i_cfg_wr    (w_cfg_wr),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_fill      (w_fill),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_off    (w_rd_off),
        .o_out_index (w_out_index)
    );

    sbx_dpath #(
        .MAX_DATA (MAX_DATA)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rx_byte   (i_rx_byte),
        .i_rd_off    (w_rd_off),
        .i_out_index (w_out_index),
        .i_stall     (i_stall),
        .o_fill      (w_fill),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_index     (o_index),
        .o_last      (o_last)
    );

    // a byte beat always starts a scan of the window
    a_scan_after_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("no scan after byte beat");

    // the window never holds more bytes than the store
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= CW'(DEPTH))
        else $error("window overfilled");

    // the final beat of a frame is an acknowledge beat
    a_last_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind && (o_index == 4'd0)))
        else $error("last beat is not an acknowledge");

    // a result is loaded only while the sequencer is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> o_stall)
        else $error("result loaded while idle");

endmodule
